/* design/ppe_pkg.sv */
// Shared types, constants and the derivative weight table for the polynomial evaluator.
`timescale 1ns / 1ps

package ppe_pkg;

   // Sequencer states, one-hot.
   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_MUL    = 4'b0010,
      ST_ADD    = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   // Item kinds carried on the request tuser bit.
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_EVAL  = 1'b1;

   localparam int unsigned NUM_AXES  = 3;
   localparam int unsigned MAX_ORDER = 2;  // position, velocity, acceleration
   localparam int unsigned POW_W     = 4;  // holds powers up to nine
   localparam int unsigned WEIGHT_W  = 7;  // largest weight is 9 * 8 = 72

   // Weight j!/(j-r)! of the term of power j in the derivative of order r.
   function automatic logic [WEIGHT_W-1:0] term_weight(input logic [POW_W-1:0] pow,
                                                       input logic [1:0] order);
      logic [7:0] pow_ext;
      logic [7:0] prod;
      pow_ext = {4'b0000, pow};
      prod    = pow_ext * (pow_ext - 8'd1);
      unique case (order)
         2'd0:    term_weight = WEIGHT_W'(1);
         2'd1:    term_weight = WEIGHT_W'(pow_ext);
         2'd2:    term_weight = prod[WEIGHT_W-1:0];
         default: term_weight = '0;
      endcase
   endfunction

endpackage

/* design/piecewise_polynomial_evaluator_top.sv */
// Piecewise polynomial evaluator: coefficient store, Horner sequencer and result register.
`timescale 1ns / 1ps

// The block keeps NUM_COEFF signed Q16.16 monomial coefficients for every segment and
// each of the axes x, y and z, and evaluates the polynomial, its first and its second
// derivative at an unsigned Q8.16 local time. A request beat with tuser low writes one
// coefficient and produces no response; req_tready stays high after it, so writes may stream
// back to back. A request beat with tuser high evaluates: the three Horner recurrences
// run together in one descending pass over the stored coefficients, and each term of
// each recurrence takes a multiply step, then an add and saturate step, on the one
// shared 32 x 25 bit multiplier, beside which a narrow multiply applies the derivative
// weight. req_tready stays low throughout an evaluation; if the output register still
// holds an unaccepted response when the pass ends, the sequencer waits until it drains.
// A finished response waits in an output register, so further writes are accepted
// while it is held. An evaluation naming axis three or a segment at or beyond
// NUM_SEGMENTS reads no coefficients and returns all zeros; such writes, and writes to
// a power at or above NUM_COEFF, are dropped. Products are truncated towards minus
// infinity, every intermediate and final value saturates to 32 bits, and the response
// tuser flags any clipping. The store is not cleared by reset: evaluate only segments
// whose coefficients have all been written.

module piecewise_polynomial_evaluator_top #(
   parameter int unsigned NUM_COEFF    = 6,
   parameter int unsigned NUM_SEGMENTS = 16
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   // [3:0] segment, [5:4] axis, [8:6] coeff_index, [40:9] coeff_value,
   // [64:41] time_value, [71:65] zero
   input  logic [71:0] req_tdata,
   // [0] opcode
   input  logic        req_tuser,
   // Response channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [31:0] position, [63:32] velocity, [95:64] acceleration
   output logic [95:0] rsp_tdata,
   // [0] saturated
   output logic        rsp_tuser
);

   localparam int unsigned DEPTH  = NUM_SEGMENTS * ppe_pkg::NUM_AXES * NUM_COEFF;
   localparam int unsigned ADDR_W = $clog2(DEPTH);
   localparam int unsigned J_W    = $clog2(NUM_COEFF);
   localparam logic [J_W-1:0] J_TOP = J_W'(NUM_COEFF - 1);
   localparam int unsigned PROD_W = 57;  // 32-bit accumulator times 25-bit signed time
   localparam int unsigned TERM_W = 40;  // 32-bit coefficient times 8-bit signed weight
   localparam int unsigned SUM_W  = 42;

   // Request fields.
   logic [3:0]  req_segment;
   logic [1:0]  req_axis;
   logic [2:0]  req_coeff_index;
   logic [31:0] req_coeff_value;
   logic [23:0] req_time_value;

   assign req_segment     = req_tdata[3:0];
   assign req_axis        = req_tdata[5:4];
   assign req_coeff_index = req_tdata[8:6];
   assign req_coeff_value = req_tdata[40:9];
   assign req_time_value  = req_tdata[64:41];

   // Registers and their next values.
   ppe_pkg::state_type state_ff, state_in;
   logic [ADDR_W-1:0]  base_ff, base_in;
   logic [23:0]        time_ff, time_in;
   logic [J_W-1:0]     j_ff, j_in;
   logic [1:0]         r_ff, r_in;
   logic [31:0]        acc_ff [3];
   logic [31:0]        acc_in [3];
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [TERM_W-1:0] term_ff, term_in;
   logic               flag_ff, flag_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [95:0]        rsp_data_ff, rsp_data_in;
   logic               rsp_flag_ff, rsp_flag_in;
   logic [31:0]        rd_data_ff;

   // Memory port controls.
   logic               mem_we;
   logic               mem_re;
   logic [ADDR_W-1:0]  wr_addr;
   logic [ADDR_W-1:0]  rd_addr;

   // Decoded request.
   logic               item_ok;
   logic               index_ok;
   logic [15:0]        row;
   logic [ADDR_W-1:0]  req_base;

   // Arithmetic.
   logic [ppe_pkg::WEIGHT_W-1:0] weight;
   logic signed [SUM_W-1:0]      floor_ext;
   logic signed [SUM_W-1:0]      term_ext;
   logic signed [SUM_W-1:0]      pre_sat;
   logic                         clip;
   logic [31:0]                  sat_val;
   logic                         is_top;

   assign req_tready = (state_ff == ppe_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_flag_ff;

   // Segment and axis must name a stored polynomial; the power must exist.
   assign item_ok  = (32'(req_segment) < 32'(NUM_SEGMENTS)) &&
                     (32'(req_axis) < 32'(ppe_pkg::NUM_AXES));
   assign index_ok = 32'(req_coeff_index) < 32'(NUM_COEFF);
   assign row      = 16'(req_segment) * 16'(ppe_pkg::NUM_AXES) + 16'(req_axis);
   assign req_base = ADDR_W'(row * 16'(NUM_COEFF));
   assign wr_addr  = req_base + ADDR_W'(req_coeff_index);

   assign weight   = ppe_pkg::term_weight(ppe_pkg::POW_W'(j_ff), r_ff);
   assign is_top   = (j_ff == J_TOP);

   // The arithmetic shift right is the floor of the Q16 product.
   assign floor_ext = $signed({{(SUM_W - (PROD_W - 16)){prod_ff[PROD_W-1]}},
                               prod_ff[PROD_W-1:16]});
   assign term_ext  = $signed({{(SUM_W - TERM_W){term_ff[TERM_W-1]}}, term_ff});
   assign pre_sat   = is_top ? term_ext : floor_ext + term_ext;

   // Out of range when the bits above bit 31 are not all copies of the sign.
   assign clip    = (pre_sat[SUM_W-1:31] != {(SUM_W - 31){1'b0}}) &&
                    (pre_sat[SUM_W-1:31] != {(SUM_W - 31){1'b1}});
   assign sat_val = !clip ? pre_sat[31:0] :
                    (pre_sat[SUM_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF);

   always_comb begin
      state_in     = state_ff;
      base_in      = base_ff;
      time_in      = time_ff;
      j_in         = j_ff;
      r_in         = r_ff;
      acc_in       = acc_ff;
      prod_in      = prod_ff;
      term_in      = term_ff;
      flag_in      = flag_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_flag_in  = rsp_flag_ff;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      rd_addr      = base_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ppe_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser == ppe_pkg::OP_WRITE) begin
                  mem_we = item_ok && index_ok;
               end else begin
                  acc_in[0] = '0;
                  acc_in[1] = '0;
                  acc_in[2] = '0;
                  flag_in   = 1'b0;
                  base_in   = req_base;
                  time_in   = req_time_value;
                  j_in      = J_TOP;
                  r_in      = '0;
                  if (item_ok) begin
                     // Fetch the highest power first.
                     mem_re   = 1'b1;
                     rd_addr  = req_base + ADDR_W'(J_TOP);
                     state_in = ppe_pkg::ST_MUL;
                  end else begin
                     state_in = ppe_pkg::ST_FINISH;
                  end
               end
            end
         end

         ppe_pkg::ST_MUL: begin
            prod_in  = $signed(acc_ff[r_ff]) * $signed({1'b0, time_ff});
            term_in  = $signed(rd_data_ff) * $signed({1'b0, weight});
            state_in = ppe_pkg::ST_ADD;
         end

         ppe_pkg::ST_ADD: begin
            acc_in[r_ff] = sat_val;
            flag_in      = flag_ff | clip;
            if ((32'(r_ff) < 32'(ppe_pkg::MAX_ORDER)) && (32'(r_ff) < 32'(j_ff))) begin
               r_in     = r_ff + 2'd1;
               state_in = ppe_pkg::ST_MUL;
            end else if (j_ff == '0) begin
               state_in = ppe_pkg::ST_FINISH;
            end else begin
               j_in     = j_ff - 1'b1;
               r_in     = '0;
               mem_re   = 1'b1;
               rd_addr  = base_ff + ADDR_W'(j_ff - 1'b1);
               state_in = ppe_pkg::ST_MUL;
            end
         end

         ppe_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {acc_ff[2], acc_ff[1], acc_ff[0]};
               rsp_flag_in  = flag_ff;
               state_in     = ppe_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = ppe_pkg::ST_IDLE;
         end
      endcase
   end

   // Coefficient store with a registered read port.
   logic [31:0] coeff_mem [DEPTH];

   always_ff @(posedge clock) begin
      if (mem_we) begin
         coeff_mem[wr_addr] <= req_coeff_value;
      end
      if (mem_re) begin
         rd_data_ff <= coeff_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ppe_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      base_ff     <= base_in;
      time_ff     <= time_in;
      j_ff        <= j_in;
      r_ff        <= r_in;
      acc_ff      <= acc_in;
      prod_ff     <= prod_in;
      term_ff     <= term_in;
      flag_ff     <= flag_in;
      rsp_data_ff <= rsp_data_in;
      rsp_flag_ff <= rsp_flag_in;
   end

endmodule

/* design/ppe_checker.sv */
// Port-level checks for the polynomial evaluator, bound to its top level.
`timescale 1ns / 1ps

module ppe_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [95:0] rsp_tdata,
   input logic        rsp_tuser
);

   // A held response beat keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response beat changed while stalled");

   // A coefficient write leaves the block ready in the next cycle.
   a_write_ready: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == ppe_pkg::OP_WRITE) |=> req_tready)
      else $error("block not ready after a coefficient write");

   // An evaluation occupies the sequencer.
   a_eval_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == ppe_pkg::OP_EVAL) |=> !req_tready)
      else $error("block ready straight after an evaluation was accepted");

   // A new response only appears at the end of an evaluation.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("response appeared without an evaluation in progress");

endmodule

bind piecewise_polynomial_evaluator_top ppe_checker u_ppe_checker (.*);
